/* sv/mseu_pkg.sv */
// Shared opcodes, function codes, execute result type and overflow helpers.
`timescale 1ns / 1ps
`default_nettype none

package mseu_pkg;

   localparam int DATA_BYTES_DEF = 1024;

   localparam logic [5:0] OP_RTYPE = 6'h00;
   localparam logic [5:0] OP_J     = 6'h02;
   localparam logic [5:0] OP_JAL   = 6'h03;
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_BGTZ  = 6'h07;
   localparam logic [5:0] OP_ADDI  = 6'h08;
   localparam logic [5:0] OP_ADDIU = 6'h09;
   localparam logic [5:0] OP_SLTI  = 6'h0a;
   localparam logic [5:0] OP_ANDI  = 6'h0c;
   localparam logic [5:0] OP_ORI   = 6'h0d;
   localparam logic [5:0] OP_NORI  = 6'h0e;
   localparam logic [5:0] OP_LUI   = 6'h0f;
   localparam logic [5:0] OP_LB    = 6'h20;
   localparam logic [5:0] OP_LH    = 6'h21;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_LBU   = 6'h24;
   localparam logic [5:0] OP_LHU   = 6'h25;
   localparam logic [5:0] OP_SB    = 6'h28;
   localparam logic [5:0] OP_SH    = 6'h29;
   localparam logic [5:0] OP_SW    = 6'h2b;
   localparam logic [5:0] OP_HALT  = 6'h3f;

   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_XOR  = 6'h26;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_NAND = 6'h28;
   localparam logic [5:0] FN_SLT  = 6'h2a;

   localparam logic [4:0] REG_ZERO = 5'd0;
   localparam logic [4:0] REG_RA   = 5'd31;

   typedef struct packed {
      logic [31:0] npc;
      logic        halt;
      logic        zw;
      logic        ov;
      logic        ae;
      logic        me;
      logic        wr;
      logic [4:0]  widx;
      logic [31:0] val;
      logic        load;
      logic        store;
      logic [5:0]  op;
      logic [31:0] addr;
      logic [31:0] sdata;
   } exec_res_type;

   function automatic logic add_ovf(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] r;
      r = a + b;
      return (~(a[31] ^ b[31])) & (a[31] ^ r[31]);
   endfunction

   function automatic logic sub_ovf(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] r;
      r = a - b;
      return (a[31] ^ b[31]) & (a[31] ^ r[31]);
   endfunction

endpackage

`default_nettype wire

/* sv/mips_subset_execute_unit_top.sv */
// Top level: pipelined execute unit for a MIPS32 subset with internal registers and data memory.
//
// req_ channel carries one instruction word per item, fetched at the next_pc of the
// previous result (or at the last value written on csr_wdata after reset).
// rsp_ channel returns one result item per instruction, in order.
// csr_wen/csr_wdata load the program counter; write only while the unit is idle.
// Pipeline: operand read, execute and address, memory access, result register.
// An accepted item passes the operand, execute, memory and result registers before its result
// appears; one item per cycle is accepted sustained while results are taken. A load whose
// destination is a source of the very next instruction costs a bubble (register read to
// memory data path). After reset the unit sweeps the register file and data memory to zero,
// one entry per cycle over max(DATA_BYTES/4, 32) entries; req_tready stays low then.
// When rsp_tready is low while a result is waiting, the whole pipeline holds; the result register keeps its item.
// After halt or a fatal memory fault every later item returns the stopped PC with halted.
`timescale 1ns / 1ps
`default_nettype none

module mips_subset_execute_unit_top #(
   parameter int DATA_BYTES = mseu_pkg::DATA_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,  // instr[31:0]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // next_pc[31:0], halted, zero_write_err, overflow_err, addr_range_err, misalign_err,
   // reg_written, reg_index[4:0], reg_value[31:0], mem_written, zero pad[3:0]
   output      logic [79:0] rsp_tdata,
   input  wire logic        csr_wen,
   input  wire logic [31:0] csr_wdata
);

   import mseu_pkg::*;

   localparam int WORDS = DATA_BYTES / 4;
   localparam int IW    = $clog2(WORDS);
   localparam int CLR_N = (WORDS > 32) ? WORDS : 32;
   localparam int CW    = $clog2(CLR_N);

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } clr_state_type;

   clr_state_type st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          clearing;

   logic        adv;
   logic        hazard;

   // operand stage
   logic        a_v_ff, a_v_in;
   logic [31:0] a_ins_ff, a_ins_in;
   logic [4:0]  a_rs;
   logic [4:0]  a_rt;
   logic [4:0]  rf_raddr_s;
   logic [4:0]  rf_raddr_t;
   logic [31:0] rf_rdata_s;
   logic [31:0] rf_rdata_t;
   logic [31:0] fwd_a;
   logic [31:0] fwd_b;

   // execute stage
   logic        b_v_ff, b_v_in;
   logic [31:0] b_ins_ff;
   logic [31:0] b_a_ff;
   logic [31:0] b_b_ff;
   logic [31:0] pc_ff, pc_in;
   logic        stop_ff, stop_in;
   exec_res_type bres;

   // memory stage
   logic         c_v_ff, c_v_in;
   exec_res_type c_res_ff;
   logic [IW-1:0] c_idx;
   logic [IW-1:0] dm_raddr;
   logic [31:0]  dm_rdata;
   logic [31:0]  c_word;
   logic [31:0]  ld_val;
   logic [31:0]  st_word;
   logic [31:0]  c_val;

   // result stage
   logic          o_v_ff, o_v_in;
   logic [31:0]   o_npc_ff;
   logic          o_halt_ff;
   logic          o_zw_ff;
   logic          o_ov_ff;
   logic          o_ae_ff;
   logic          o_me_ff;
   logic          o_wr_ff;
   logic [4:0]    o_widx_ff;
   logic [31:0]   o_val_ff;
   logic          o_mw_ff;
   logic [IW-1:0] o_midx_ff;
   logic [31:0]   o_mdata_ff;

   // write ports
   logic          rf_we;
   logic [4:0]    rf_waddr;
   logic [31:0]   rf_wdata;
   logic          dm_we;
   logic [IW-1:0] dm_waddr;
   logic [31:0]   dm_wdata;

   assign clearing   = (st_ff == ST_CLEAR);
   assign adv        = !o_v_ff || rsp_tready;
   assign a_rs       = a_ins_ff[25:21];
   assign a_rt       = a_ins_ff[20:16];
   assign hazard     = a_v_ff && b_v_ff && bres.load && bres.wr &&
                       (bres.widx == a_rs || bres.widx == a_rt);
   assign req_tready = !clearing && adv && !hazard;

   // clearing sweep
   always_comb begin
      st_in  = st_ff;
      cnt_in = cnt_ff;
      unique case (st_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CLR_N - 1)) begin
               st_in = ST_RUN;
            end
         end
         ST_RUN:  cnt_in = cnt_ff;
         default: st_in = ST_CLEAR;
      endcase
   end

   // register file: two read copies, one shared write
   assign rf_raddr_s = req_tready ? req_tdata[25:21] : a_rs;
   assign rf_raddr_t = req_tready ? req_tdata[20:16] : a_rt;
   assign rf_we      = clearing || (adv && c_v_ff && c_res_ff.wr);
   assign rf_waddr   = clearing ? cnt_ff[4:0] : c_res_ff.widx;
   assign rf_wdata   = clearing ? 32'd0 : c_val;

   mseu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_s (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (rf_raddr_s),
      .rd_data (rf_rdata_s)
   );

   mseu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_t (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (rf_raddr_t),
      .rd_data (rf_rdata_t)
   );

   // operand bypass: newest writer first
   always_comb begin
      if (b_v_ff && bres.wr && !bres.load && bres.widx == a_rs) begin
         fwd_a = bres.val;
      end else if (c_v_ff && c_res_ff.wr && c_res_ff.widx == a_rs) begin
         fwd_a = c_val;
      end else if (o_v_ff && o_wr_ff && o_widx_ff == a_rs) begin
         fwd_a = o_val_ff;
      end else begin
         fwd_a = rf_rdata_s;
      end
      if (b_v_ff && bres.wr && !bres.load && bres.widx == a_rt) begin
         fwd_b = bres.val;
      end else if (c_v_ff && c_res_ff.wr && c_res_ff.widx == a_rt) begin
         fwd_b = c_val;
      end else if (o_v_ff && o_wr_ff && o_widx_ff == a_rt) begin
         fwd_b = o_val_ff;
      end else begin
         fwd_b = rf_rdata_t;
      end
   end

   mseu_exec #(.DATA_BYTES(DATA_BYTES)) u_exec (
      .instr   (b_ins_ff),
      .op_a    (b_a_ff),
      .op_b    (b_b_ff),
      .pc      (pc_ff),
      .stopped (stop_ff),
      .res     (bres)
   );

   // data memory
   assign c_idx    = c_res_ff.addr[IW+1:2];
   assign dm_raddr = adv ? bres.addr[IW+1:2] : c_idx;
   assign dm_we    = clearing || (adv && c_v_ff && c_res_ff.store);
   assign dm_waddr = clearing ? cnt_ff[IW-1:0] : c_idx;
   assign dm_wdata = clearing ? 32'd0 : st_word;

   mseu_ram #(.WIDTH(32), .DEPTH(WORDS)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_addr (dm_raddr),
      .rd_data (dm_rdata)
   );

   assign c_word = (o_v_ff && o_mw_ff && o_midx_ff == c_idx) ? o_mdata_ff : dm_rdata;

   mseu_lsu u_lsu (
      .op      (c_res_ff.op),
      .offset  (c_res_ff.addr[1:0]),
      .word    (c_word),
      .sdata   (c_res_ff.sdata),
      .ld_val  (ld_val),
      .st_word (st_word)
   );

   assign c_val = c_res_ff.load ? ld_val : c_res_ff.val;

   // stage valids and architectural state
   always_comb begin
      a_v_in   = a_v_ff;
      a_ins_in = a_ins_ff;
      b_v_in   = b_v_ff;
      c_v_in   = c_v_ff;
      o_v_in   = o_v_ff;
      pc_in    = pc_ff;
      stop_in  = stop_ff;
      if (adv) begin
         o_v_in = c_v_ff;
         c_v_in = b_v_ff;
         b_v_in = a_v_ff && !hazard;
         if (!hazard) begin
            a_v_in   = req_tvalid && req_tready;
            a_ins_in = req_tdata;
         end
         if (b_v_ff) begin
            pc_in   = bres.npc;
            stop_in = bres.halt;
         end
      end
      if (csr_wen) begin
         pc_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_CLEAR;
         cnt_ff  <= '0;
         a_v_ff  <= 1'b0;
         b_v_ff  <= 1'b0;
         c_v_ff  <= 1'b0;
         o_v_ff  <= 1'b0;
         pc_ff   <= 32'd0;
         stop_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         a_v_ff  <= a_v_in;
         b_v_ff  <= b_v_in;
         c_v_ff  <= c_v_in;
         o_v_ff  <= o_v_in;
         pc_ff   <= pc_in;
         stop_ff <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ins_ff <= a_ins_in;
      if (adv) begin
         b_ins_ff   <= a_ins_ff;
         b_a_ff     <= fwd_a;
         b_b_ff     <= fwd_b;
         c_res_ff   <= bres;
         o_npc_ff   <= c_res_ff.npc;
         o_halt_ff  <= c_res_ff.halt;
         o_zw_ff    <= c_res_ff.zw;
         o_ov_ff    <= c_res_ff.ov;
         o_ae_ff    <= c_res_ff.ae;
         o_me_ff    <= c_res_ff.me;
         o_wr_ff    <= c_res_ff.wr;
         o_widx_ff  <= c_res_ff.wr ? c_res_ff.widx : REG_ZERO;
         o_val_ff   <= c_res_ff.wr ? c_val : 32'd0;
         o_mw_ff    <= c_res_ff.store;
         o_midx_ff  <= c_idx;
         o_mdata_ff <= st_word;
      end
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = {4'd0, o_mw_ff, o_val_ff, o_widx_ff, o_wr_ff, o_me_ff, o_ae_ff,
                        o_ov_ff, o_zw_ff, o_halt_ff, o_npc_ff};

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (st_ff == ST_RUN))
      else $error("item accepted during memory clear");

   a_hazard_stall: assert property (@(posedge clock) disable iff (reset)
      (hazard && adv) |=> !b_v_ff)
      else $error("load-use bubble not inserted");

   a_wr_nonzero: assert property (@(posedge clock) disable iff (reset)
      (o_v_ff && o_wr_ff) |-> (o_widx_ff != REG_ZERO))
      else $error("register zero written");

   a_store_clean: assert property (@(posedge clock) disable iff (reset)
      (o_v_ff && o_mw_ff) |-> !(o_ae_ff || o_me_ff || o_halt_ff))
      else $error("store committed on faulting access");

endmodule

`default_nettype wire

/* sv/mseu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mseu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/mseu_exec.sv */
// Decode and execute: next PC, ALU result, flags and memory address of one instruction.
`timescale 1ns / 1ps
`default_nettype none

module mseu_exec #(
   parameter int DATA_BYTES = mseu_pkg::DATA_BYTES_DEF
) (
   input  wire logic [31:0]           instr,
   input  wire logic [31:0]           op_a,
   input  wire logic [31:0]           op_b,
   input  wire logic [31:0]           pc,
   input  wire logic                  stopped,
   output      mseu_pkg::exec_res_type res
);

   import mseu_pkg::*;

   logic [5:0]  op;
   logic [5:0]  fn;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sh;
   logic [31:0] lo16;
   logic [31:0] imm;
   logic [31:0] pc4;
   logic [31:0] addr;
   logic [31:0] brt;
   logic [2:0]  sz;
   logic [2:0]  szm;
   logic        has;
   logic        ls;
   logic        st;

   assign op   = instr[31:26];
   assign rt   = instr[20:16];
   assign rd   = instr[15:11];
   assign sh   = instr[10:6];
   assign fn   = instr[5:0];
   assign lo16 = {16'h0000, instr[15:0]};
   assign imm  = {{16{instr[15]}}, instr[15:0]};
   assign pc4  = pc + 32'd4;
   assign addr = op_a + imm;
   assign brt  = pc4 + {imm[29:0], 2'b00};

   always_comb begin
      res       = '0;
      res.npc   = pc4;
      res.op    = op;
      res.addr  = addr;
      res.sdata = op_b;
      sz        = 3'd0;
      szm       = 3'd0;
      has       = 1'b0;
      ls        = 1'b0;
      st        = 1'b0;
      if (stopped) begin
         res.npc  = pc;
         res.halt = 1'b1;
      end else if (op == OP_RTYPE) begin
         if (fn == FN_JR) begin
            res.npc = op_a;
         end else begin
            has = 1'b1;
            unique case (fn)
               FN_ADD: begin
                  res.ov  = add_ovf(op_a, op_b);
                  res.val = op_a + op_b;
               end
               FN_ADDU: res.val = op_a + op_b;
               FN_SUB: begin
                  res.ov  = sub_ovf(op_a, op_b);
                  res.val = op_a - op_b;
               end
               FN_AND:  res.val = op_a & op_b;
               FN_OR:   res.val = op_a | op_b;
               FN_XOR:  res.val = op_a ^ op_b;
               FN_NOR:  res.val = ~(op_a | op_b);
               FN_NAND: res.val = ~(op_a & op_b);
               FN_SLT:  res.val = {31'd0, $signed(op_a) < $signed(op_b)};
               FN_SLL:  res.val = op_b << sh;
               FN_SRL:  res.val = op_b >> sh;
               FN_SRA:  res.val = $unsigned($signed(op_b) >>> sh);
               default: has = 1'b0;
            endcase
            if (rd == REG_ZERO) begin
               // an SLL with rt, rd and shift amount zero (the nop) is exempt
               res.zw = !(rt == REG_ZERO && sh == 5'd0 && fn == FN_SLL);
            end else if (has) begin
               res.wr   = 1'b1;
               res.widx = rd;
            end
         end
      end else if (op == OP_J || op == OP_JAL) begin
         res.npc = {pc4[31:28], instr[25:0], 2'b00};
         if (op == OP_JAL) begin
            res.wr   = 1'b1;
            res.widx = REG_RA;
            res.val  = pc4;
         end
      end else if (op == OP_HALT) begin
         res.halt = 1'b1;
      end else begin
         has = 1'b1;
         unique case (op) inside
            OP_ADDI: begin
               res.ov  = add_ovf(op_a, imm);
               res.val = addr;
            end
            OP_ADDIU: res.val = addr;
            OP_LUI:   res.val = {instr[15:0], 16'h0000};
            OP_ANDI:  res.val = op_a & lo16;
            OP_ORI:   res.val = op_a | lo16;
            OP_NORI:  res.val = ~(op_a | lo16);
            OP_SLTI:  res.val = {31'd0, $signed(op_a) < $signed(imm)};
            OP_LW: begin
               ls = 1'b1;
               sz = 3'd4;
            end
            OP_LH, OP_LHU: begin
               ls = 1'b1;
               sz = 3'd2;
            end
            OP_LB, OP_LBU: begin
               ls = 1'b1;
               sz = 3'd1;
            end
            OP_SW: begin
               ls  = 1'b1;
               st  = 1'b1;
               sz  = 3'd4;
               has = 1'b0;
            end
            OP_SH: begin
               ls  = 1'b1;
               st  = 1'b1;
               sz  = 3'd2;
               has = 1'b0;
            end
            OP_SB: begin
               ls  = 1'b1;
               st  = 1'b1;
               sz  = 3'd1;
               has = 1'b0;
            end
            OP_BEQ, OP_BNE: begin
               has    = 1'b0;
               res.ov = add_ovf(pc4, {imm[29:0], 2'b00});
               if ((op == OP_BEQ) == (op_a == op_b)) begin
                  res.npc = brt;
               end
            end
            OP_BGTZ: begin
               has = 1'b0;
               if (op_a != 32'd0 && !op_a[31]) begin
                  res.npc = brt;
               end
            end
            default: has = 1'b0;
         endcase
         if (ls) begin
            szm    = sz - 3'd1;
            res.ov = add_ovf(op_a, imm);
            res.ae = addr[31] ||
                     (({1'b0, addr} + {30'd0, sz}) > 33'(DATA_BYTES));
            res.me = |(addr[1:0] & szm[1:0]);
            if (res.ae || res.me) begin
               res.halt = 1'b1;
               has      = 1'b0;
            end else begin
               res.load  = !st;
               res.store = st;
            end
         end
         if (has) begin
            if (rt == REG_ZERO) begin
               res.zw = 1'b1;
            end else begin
               res.wr   = 1'b1;
               res.widx = rt;
            end
         end
      end
   end

endmodule

`default_nettype wire

/* sv/mseu_lsu.sv */
// Big-endian load extraction and store merge on one memory word.
`timescale 1ns / 1ps
`default_nettype none

module mseu_lsu (
   input  wire logic [5:0]  op,
   input  wire logic [1:0]  offset,
   input  wire logic [31:0] word,
   input  wire logic [31:0] sdata,
   output      logic [31:0] ld_val,
   output      logic [31:0] st_word
);

   import mseu_pkg::*;

   logic [15:0] half;
   logic [7:0]  byte_sel;

   always_comb begin
      half = offset[1] ? word[15:0] : word[31:16];
      case (offset)
         2'd0:    byte_sel = word[31:24];
         2'd1:    byte_sel = word[23:16];
         2'd2:    byte_sel = word[15:8];
         default: byte_sel = word[7:0];
      endcase
   end

   always_comb begin
      case (op) inside
         OP_LH:   ld_val = {{16{half[15]}}, half};
         OP_LHU:  ld_val = {16'h0000, half};
         OP_LB:   ld_val = {{24{byte_sel[7]}}, byte_sel};
         OP_LBU:  ld_val = {24'h000000, byte_sel};
         default: ld_val = word;
      endcase
   end

   always_comb begin
      st_word = word;
      case (op) inside
         OP_SW: st_word = sdata;
         OP_SH: begin
            if (offset[1]) begin
               st_word[15:0] = sdata[15:0];
            end else begin
               st_word[31:16] = sdata[15:0];
            end
         end
         OP_SB: begin
            case (offset)
               2'd0:    st_word[31:24] = sdata[7:0];
               2'd1:    st_word[23:16] = sdata[7:0];
               2'd2:    st_word[15:8]  = sdata[7:0];
               default: st_word[7:0]   = sdata[7:0];
            endcase
         end
         default: st_word = word;
      endcase
   end

endmodule

`default_nettype wire

/* bench/mseu_checker.sv */
// Checker for the MIPS subset execute unit: predicts each result item and compares it.
`timescale 1ns / 1ps

module mseu_checker
   import mseu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [79:0] rsp_tdata,
   input  wire logic        csr_wen,
   input  wire logic [31:0] csr_wdata,
   output int               fail_count,
   output int               pending
);

   localparam int MEM_BYTES = DATA_BYTES_DEF;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        zero_write_err;
      logic        overflow_err;
      logic        addr_range_err;
      logic        misalign_err;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_written;
   } exec_result_t;

   logic [31:0]  pc_q;
   logic [31:0]  gpr [32];
   logic [31:0]  dmem [MEM_BYTES / 4];
   logic         stopped_q;
   exec_result_t results_due [$];

   function automatic logic sum_ovf(logic [31:0] a, logic [31:0] b);
      logic [31:0] r;
      r = a + b;
      return (a[31] == b[31]) && (r[31] != a[31]);
   endfunction

   function automatic exec_result_t execute_instr(logic [31:0] ins);
      exec_result_t res;
      logic [5:0]   op, fn;
      logic [4:0]   rs, rt, rd, sh;
      logic [31:0]  imm, lo16, a, b, pc4, npc, val, addr, word;
      logic [4:0]   widx;
      logic [32:0]  a_end;
      int           sz, shb, shh;
      logic         has, wr, load, store, halt;

      res = '0;
      if (stopped_q) begin
         res.next_pc = pc_q;
         res.halted = 1'b1;
         return res;
      end
      op = ins[31:26];
      rs = ins[25:21];
      rt = ins[20:16];
      rd = ins[15:11];
      sh = ins[10:6];
      fn = ins[5:0];
      lo16 = {16'h0, ins[15:0]};
      imm = {{16{ins[15]}}, ins[15:0]};
      a = gpr[rs];
      b = gpr[rt];
      pc4 = pc_q + 32'd4;
      npc = pc4;
      val = '0;
      widx = '0;
      sz = 0;
      has = 1'b0;
      wr = 1'b0;
      load = 1'b0;
      store = 1'b0;
      halt = 1'b0;

      if (op == OP_RTYPE) begin
         if (fn == FN_JR) begin
            npc = a;
         end else begin
            has = 1'b1;
            case (fn)
               FN_ADD: begin
                  res.overflow_err = sum_ovf(a, b);
                  val = a + b;
               end
               FN_ADDU: val = a + b;
               FN_SUB: begin
                  val = a - b;
                  res.overflow_err = (a[31] != b[31]) && (val[31] != a[31]);
               end
               FN_AND:  val = a & b;
               FN_OR:   val = a | b;
               FN_XOR:  val = a ^ b;
               FN_NOR:  val = ~(a | b);
               FN_NAND: val = ~(a & b);
               FN_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
               FN_SLL:  val = b << sh;
               FN_SRL:  val = b >> sh;
               FN_SRA:  val = $signed(b) >>> sh;
               default: has = 1'b0;
            endcase
            if (rd == REG_ZERO) begin
               if (!(rt == REG_ZERO && sh == 5'd0 && fn == FN_SLL))
                  res.zero_write_err = 1'b1;
            end else if (has) begin
               wr = 1'b1;
               widx = rd;
            end
         end
      end else if (op == OP_J || op == OP_JAL) begin
         npc = {pc4[31:28], ins[25:0], 2'b00};
         if (op == OP_JAL) begin
            wr = 1'b1;
            widx = REG_RA;
            val = pc4;
         end
      end else if (op == OP_HALT) begin
         halt = 1'b1;
      end else begin
         has = 1'b1;
         case (op)
            OP_ADDI: begin
               res.overflow_err = sum_ovf(a, imm);
               val = a + imm;
            end
            OP_ADDIU: val = a + imm;
            OP_LUI:   val = lo16 << 16;
            OP_ANDI:  val = a & lo16;
            OP_ORI:   val = a | lo16;
            OP_NORI:  val = ~(a | lo16);
            OP_SLTI:  val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
            OP_LW: begin
               load = 1'b1;
               sz = 4;
            end
            OP_LH, OP_LHU: begin
               load = 1'b1;
               sz = 2;
            end
            OP_LB, OP_LBU: begin
               load = 1'b1;
               sz = 1;
            end
            OP_SW: begin
               store = 1'b1;
               sz = 4;
               has = 1'b0;
            end
            OP_SH: begin
               store = 1'b1;
               sz = 2;
               has = 1'b0;
            end
            OP_SB: begin
               store = 1'b1;
               sz = 1;
               has = 1'b0;
            end
            OP_BEQ, OP_BNE: begin
               has = 1'b0;
               res.overflow_err = sum_ovf(pc4, imm << 2);
               if ((op == OP_BEQ) == (a == b))
                  npc = pc4 + (imm << 2);
            end
            OP_BGTZ: begin
               has = 1'b0;
               if (a != 32'd0 && !a[31])
                  npc = pc4 + (imm << 2);
            end
            default: has = 1'b0;
         endcase
         if (load || store) begin
            res.overflow_err = sum_ovf(a, imm);
            addr = a + imm;
            a_end = {1'b0, addr} + 33'(sz);
            res.addr_range_err = addr[31] || (a_end > 33'(MEM_BYTES));
            res.misalign_err = (addr & 32'(sz - 1)) != 32'd0;
            if (res.addr_range_err || res.misalign_err) begin
               halt = 1'b1;
               has = 1'b0;
            end else begin
               shb = (3 - int'(addr[1:0])) * 8;
               shh = addr[1] ? 0 : 16;
               word = dmem[addr[9:2]];
               case (op)
                  OP_LW:  val = word;
                  OP_LH:  val = {{16{word[shh + 15]}}, 16'(word >> shh)};
                  OP_LHU: val = {16'h0, 16'(word >> shh)};
                  OP_LB:  val = {{24{word[shb + 7]}}, 8'(word >> shb)};
                  OP_LBU: val = {24'h0, 8'(word >> shb)};
                  OP_SW:  dmem[addr[9:2]] = b;
                  OP_SH:  dmem[addr[9:2]] = (word & ~(32'hffff << shh))
                                            | ({16'h0, b[15:0]} << shh);
                  default: dmem[addr[9:2]] = (word & ~(32'hff << shb))
                                             | ({24'h0, b[7:0]} << shb);
               endcase
               res.mem_written = store;
            end
         end
         if (has) begin
            if (rt == REG_ZERO) begin
               res.zero_write_err = 1'b1;
            end else begin
               wr = 1'b1;
               widx = rt;
            end
         end
      end

      if (wr && widx != REG_ZERO)
         gpr[widx] = val;
      else
         wr = 1'b0;
      if (halt)
         stopped_q = 1'b1;
      pc_q = npc;

      res.next_pc = npc;
      res.halted = halt;
      res.reg_written = wr;
      res.reg_index = wr ? widx : 5'd0;
      res.reg_value = wr ? val : 32'd0;
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, exp_v,
                  act_v);
         fail_count++;
      end
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      exec_result_t exp_r, act_r;
      if (reset) begin
         pc_q = '0;
         stopped_q = 1'b0;
         for (int i = 0; i < 32; i++)
            gpr[i] = '0;
         for (int i = 0; i < MEM_BYTES / 4; i++)
            dmem[i] = '0;
         results_due.delete();
      end else begin
         if (csr_wen)
            pc_q = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            act_r = {rsp_tdata[31:0], rsp_tdata[32], rsp_tdata[33], rsp_tdata[34],
                     rsp_tdata[35], rsp_tdata[36], rsp_tdata[37], rsp_tdata[42:38],
                     rsp_tdata[74:43], rsp_tdata[75]};
            if (results_due.size() == 0) begin
               $display("%0t: result item with none expected, actual 0x%020h", $time,
                        rsp_tdata);
               fail_count++;
            end else begin
               exp_r = results_due.pop_front();
               check_field("next_pc", exp_r.next_pc, act_r.next_pc);
               check_field("halted", exp_r.halted, act_r.halted);
               check_field("zero_write_err", exp_r.zero_write_err, act_r.zero_write_err);
               check_field("overflow_err", exp_r.overflow_err, act_r.overflow_err);
               check_field("addr_range_err", exp_r.addr_range_err, act_r.addr_range_err);
               check_field("misalign_err", exp_r.misalign_err, act_r.misalign_err);
               check_field("reg_written", exp_r.reg_written, act_r.reg_written);
               check_field("reg_index", exp_r.reg_index, act_r.reg_index);
               check_field("reg_value", exp_r.reg_value, act_r.reg_value);
               check_field("mem_written", exp_r.mem_written, act_r.mem_written);
            end
         end
         if (req_tvalid && req_tready)
            results_due.push_back(execute_instr(req_tdata));
      end
      pending = results_due.size();
   end

endmodule

/* bench/tb_mips_subset_execute_unit_top.sv */
// Testbench top: instruction stimulus, result-side stalls and verdict for the execute unit.
`timescale 1ns / 1ps

module tb_mips_subset_execute_unit_top;
   import mseu_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic        csr_wen;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          burst_left;
   int          stall_cnt;

   mips_subset_execute_unit_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   mseu_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   // result-side stall pattern, mode chosen by bits 7:6 of the stall counter
   always @(negedge clock) begin
      stall_cnt <= stall_cnt + 1;
      case (stall_cnt[7:6])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 1) == 0);
         2'd2: rsp_tready <= ($urandom_range(0, 4) != 0);
         default: rsp_tready <= (stall_cnt[1:0] == 2'd3);
      endcase
   end

   function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sh);
      return {OP_RTYPE, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] random_instr();
      logic [5:0] fns [13] = '{FN_ADD, FN_ADDU, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR,
                               FN_NAND, FN_SLT, FN_SLL, FN_SRL, FN_SRA, FN_JR};
      logic [5:0] iops [10] = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_NORI,
                                OP_LUI, OP_BEQ, OP_BNE, OP_BGTZ};
      logic [5:0] mops [8] = '{OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB};
      logic [31:0] w;
      logic [5:0]  op;
      int          sz;
      w = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            if ($urandom_range(0, 9) != 0)
               w[5:0] = fns[$urandom_range(0, 12)];
            w[31:26] = OP_RTYPE;
         end
         3, 4, 5: w[31:26] = iops[$urandom_range(0, 9)];
         6, 7, 8: begin
            op = mops[$urandom_range(0, 7)];
            sz = (op == OP_LW || op == OP_SW) ? 4 :
                 (op == OP_LH || op == OP_LHU || op == OP_SH) ? 2 : 1;
            w = itype(op, REG_ZERO, w[20:16],
                      16'($urandom_range(0, DATA_BYTES_DEF / sz - 1) * sz));
         end
         default: begin
            if ($urandom_range(0, 1) == 0)
               w[31:26] = $urandom_range(0, 1) ? OP_J : OP_JAL;
            else begin
               do
                  op = 6'($urandom);
               while (op == OP_HALT || op[5] || op <= OP_JAL || op == OP_BEQ ||
                      op == OP_BNE || op == OP_BGTZ || (op >= OP_ADDI && op <= OP_LUI));
               w[31:26] = op;
            end
         end
      endcase
      return w;
   endfunction

   task automatic send(logic [31:0] w);
      if (burst_left == 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end else
         @(negedge clock);
      burst_left--;
      req_tdata = w;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_pc(logic [31:0] v);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (5) @(negedge clock);
      csr_wen = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   initial begin
      logic [31:0] directed [28];
      int          n;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      stall_cnt = 0;
      csr_wen = 1'b0;
      csr_wdata = '0;
      burst_left = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      while (!req_tready) @(negedge clock);

      directed = '{32'h0,
                   itype(OP_LUI, REG_ZERO, 5'd1, 16'h7fff),
                   itype(OP_ORI, 5'd1, 5'd1, 16'hffff),
                   rtype(FN_ADD, 5'd1, 5'd1, 5'd2, 5'd0),
                   itype(OP_LUI, REG_ZERO, 5'd3, 16'h8000),
                   rtype(FN_SUB, 5'd3, 5'd1, 5'd4, 5'd0),
                   itype(OP_ADDI, 5'd1, REG_ZERO, 16'h0001),
                   rtype(FN_SRA, REG_ZERO, 5'd3, 5'd5, 5'd4),
                   rtype(FN_SRA, REG_ZERO, 5'd3, 5'd6, 5'd0),
                   rtype(FN_SRL, REG_ZERO, 5'd3, 5'd7, 5'd31),
                   rtype(FN_SLL, REG_ZERO, 5'd1, REG_ZERO, 5'd3),
                   itype(OP_SW, REG_ZERO, 5'd1, 16'd1020),
                   itype(OP_SB, REG_ZERO, 5'd3, 16'd1021),
                   itype(OP_SH, REG_ZERO, REG_ZERO, 16'd1022),
                   itype(OP_LW, REG_ZERO, 5'd8, 16'd1020),
                   itype(OP_LB, REG_ZERO, 5'd9, 16'd1020),
                   itype(OP_LBU, REG_ZERO, 5'd10, 16'd1020),
                   itype(OP_LH, REG_ZERO, 5'd11, 16'd1020),
                   itype(OP_LHU, 5'd0, 5'd12, 16'd1020),
                   itype(OP_NORI, 5'd3, 5'd13, 16'h8001),
                   itype(OP_SLTI, 5'd3, 5'd14, 16'hffff),
                   itype(OP_LUI, REG_ZERO, REG_ZERO, 16'hffff),
                   {OP_JAL, 26'h3ffffff},
                   rtype(FN_JR, REG_RA, REG_ZERO, REG_ZERO, 5'd0),
                   {OP_J, 26'h0000010},
                   itype(OP_BEQ, 5'd1, 5'd1, 16'h8000),
                   rtype(6'h3f, 5'd1, 5'd2, 5'd3, 5'd0),
                   {6'h3e, 26'h2aaaaaa}};

      write_pc(32'h0);
      foreach (directed[i])
         send(directed[i]);

      write_pc(32'hfffffffc);
      for (n = 0; n < 150; n++) send(random_instr());
      write_pc(32'h7ffffff0);
      for (n = 0; n < 150; n++) send(random_instr());
      write_pc($urandom & 32'hfffffffc);
      for (n = 0; n < 200; n++) send(random_instr());

      // ending: one stopping item (in one mode after two setup items), then items the stopped unit must ignore
      case ($urandom_range(0, 3))
         0: send({OP_HALT, 26'($urandom)});
         1: begin
            send(itype(OP_LUI, REG_ZERO, 5'd5, 16'h7fff));
            send(itype(OP_ORI, 5'd5, 5'd5, 16'hffff));
            send(itype(OP_LH, 5'd5, REG_ZERO, 16'h0002));
         end
         2: send(itype(OP_SW, REG_ZERO, 5'd7, 16'h0002));
         default: send(itype(OP_LW, REG_ZERO, 5'd6, 16'd1024));
      endcase
      repeat (3) send(random_instr());

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
